>>> src/ilir_pkg.sv
// Shared types and constants for the indexed list insert/remove block.
// No dependencies; used by ilir_cell and indexed_list_insert_remove.
package ilir_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_SET    = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  // Command broadcast from the control to every cell in the chain.
  typedef struct packed {
    logic wr;  // request is valid and changes the list
    req_e op;
  } cmd_t;

endpackage

>>> src/indexed_list_insert_remove.sv
// Top level of the indexed list: range checks, entry count, cell chain and
// output register. Depends on ilir_pkg and ilir_cell.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, req_type_i,       | in
//           | position_i, value_i                       |
//   out     | out_valid_o, out_stall_i, read_value_o,   | out
//           | status_o, item_count_o                    |
//
// Every item completes in the cycle it is accepted: all cells shift in
// parallel and the result is written to the output register. Sustained
// rate is one item per cycle when not stalled. in_stall_o is high only
// while a result waits in the output register and out_stall_i is high.
// Reset clears the entry count and output valid; cell contents are kept.
module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [ilir_pkg::PosW-1:0]     position_i,
  input  logic signed [ilir_pkg::DataW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ilir_pkg::DataW-1:0] read_value_o,
  output logic [ilir_pkg::StatusW-1:0]  status_o,
  output logic [ilir_pkg::CountW-1:0]   item_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > ilir_pkg::PosW) ? CW : ilir_pkg::PosW;

  logic [CW-1:0]               count_q, count_d;
  logic                        out_valid_q;
  logic [ilir_pkg::DataW-1:0]  read_value_q, read_value_d;
  logic [ilir_pkg::StatusW-1:0] status_q, status_d;
  logic [ilir_pkg::CountW-1:0] item_count_q;

  logic                        accept;
  ilir_pkg::req_e              op;
  ilir_pkg::cmd_t              cmd;
  logic [PW-1:0]               pos_x, cnt_x;
  logic                        in_range, ins_pos_ok, full;
  logic [ilir_pkg::DataW-1:0]  sel_value;

  logic [ilir_pkg::DataW-1:0]  cell_val [CAPACITY];
  logic [ilir_pkg::DataW-1:0]  hit_val  [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = ilir_pkg::req_e'(req_type_i);

  assign pos_x      = PW'(position_i);
  assign cnt_x      = PW'(count_q);
  assign in_range   = (pos_x < cnt_x);
  assign ins_pos_ok = (pos_x <= cnt_x);
  assign full       = (count_q == CW'(CAPACITY));

  // At most one cell matches the position, so an OR of masked values reads it.
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_value = sel_value | hit_val[i];
    end
  end

  always_comb begin
    count_d      = count_q;
    status_d     = ilir_pkg::ST_DONE;
    read_value_d = '0;
    cmd.op       = op;
    cmd.wr       = 1'b0;
    unique case (op)
      ilir_pkg::REQ_GET: begin
        if (in_range) read_value_d = sel_value;
        else begin
          read_value_d = '1;
          status_d     = ilir_pkg::ST_RANGE;
        end
      end
      ilir_pkg::REQ_SET: begin
        if (in_range) cmd.wr = accept;
        else status_d = ilir_pkg::ST_RANGE;
      end
      ilir_pkg::REQ_INSERT: begin
        priority if (!ins_pos_ok) status_d = ilir_pkg::ST_RANGE;
        else if (full) status_d = ilir_pkg::ST_FULL;
        else begin
          cmd.wr  = accept;
          count_d = count_q + CW'(1);
        end
      end
      ilir_pkg::REQ_REMOVE: begin
        if (in_range) begin
          read_value_d = sel_value;
          cmd.wr       = accept;
          count_d      = count_q - CW'(1);
        end else status_d = ilir_pkg::ST_RANGE;
      end
      default: status_d = ilir_pkg::ST_DONE;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ilir_pkg::DataW-1:0] prev_v, next_v;
    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_prev
      assign prev_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_next
      assign next_v = cell_val[g+1];
    end
    ilir_cell #(
      .Idx(g),
      .PW (PW)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .pos_i  (pos_x),
      .value_i(value_i),
      .prev_i (prev_v),
      .next_i (next_v),
      .cell_o (cell_val[g]),
      .hit_o  (hit_val[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result while the downstream side stalls.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
      item_count_q <= ilir_pkg::CountW'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign item_count_o = item_count_q;

endmodule

>>> src/ilir_cell.sv
// One storage cell of the list chain: holds one entry and takes data from
// its lower or upper neighbor on insert or remove. Depends on ilir_pkg.
module ilir_cell #(
  parameter int unsigned Idx = 0,
  parameter int unsigned PW  = 7
) (
  input  logic                      clk_i,
  input  ilir_pkg::cmd_t            cmd_i,
  input  logic [PW-1:0]             pos_i,
  input  logic [ilir_pkg::DataW-1:0] value_i,
  input  logic [ilir_pkg::DataW-1:0] prev_i,
  input  logic [ilir_pkg::DataW-1:0] next_i,
  output logic [ilir_pkg::DataW-1:0] cell_o,
  output logic [ilir_pkg::DataW-1:0] hit_o
);

  logic [ilir_pkg::DataW-1:0] cell_q, cell_d;
  logic                       hit, above;

  assign hit   = (pos_i == PW'(Idx));
  assign above = (pos_i < PW'(Idx));

  always_comb begin
    cell_d = cell_q;
    if (cmd_i.wr) begin
      unique case (cmd_i.op)
        ilir_pkg::REQ_SET: begin
          if (hit) cell_d = value_i;
        end
        ilir_pkg::REQ_INSERT: begin
          if (hit) cell_d = value_i;
          else if (above) cell_d = prev_i;
        end
        ilir_pkg::REQ_REMOVE: begin
          if (hit || above) cell_d = next_i;
        end
        default: cell_d = cell_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;
  assign hit_o  = hit ? cell_q : '0;

endmodule
